// ===== sv/assert_macros.svh =====
// Assertion macros shared by the shell sort engine RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge.
`define SSE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("shell sort engine check failed");

// Check a consequent in the cycle after an antecedent.
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shell sort engine sequence check failed");

`endif

// ===== sv/ssort_pkg.sv =====
// Shared types for the shell sort engine: element width and the
// command and status bundles between controller and datapath.
// No dependencies.
package ssort_pkg;

  localparam int DataW = 32;

  typedef struct packed {
    logic load;
    logic init_gap;
    logic set_i;
    logic halve_gap;
    logic rd_i;
    logic cap_held;
    logic rd_k;
    logic wr_shift;
    logic wr_held;
    logic clr_j;
    logic rd_o;
    logic out_ld;
    logic clear_set;
  } ssort_cmd_t;

  typedef struct packed {
    logic gap_zero;
    logic i_ge_n;
    logic k_neg;
    logic gt;
    logic j_last;
    logic out_free;
  } ssort_stat_t;

endpackage

// ===== sv/ssort_dp.sv =====
// Datapath of the shell sort engine: element memory, counters, held
// element, compare and output register. Depends on ssort_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ssort_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssort_pkg::ssort_cmd_t               cmd_i,
  output ssort_pkg::ssort_stat_t              stat_o,
  input  logic signed [ssort_pkg::DataW-1:0]  value_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [ssort_pkg::DataW-1:0]  sorted_value_o,
  output logic                                final_res_o,
  output logic                                dropped_o
);
  import ssort_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [DataW-1:0]        mem [CAPACITY];
  logic [CW-1:0]           cnt_q, gap_q, i_q, j_q;
  logic signed [CW:0]      k_q;
  logic                    ovf_q;
  logic signed [DataW-1:0] held_q;
  logic [DataW-1:0]        rd_data_q;
  logic                    out_valid_q, final_q, dropped_q;
  logic signed [DataW-1:0] out_value_q;

  logic                    full;
  logic [CW-1:0]           cnt_inc;
  logic signed [CW:0]      gap_s;
  logic signed [CW:0]      kg;
  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [DataW-1:0]        wr_data;

  assign full    = (cnt_q == CW'(CAPACITY));
  assign cnt_inc = full ? cnt_q : cnt_q + CW'(1);
  assign gap_s   = signed'({1'b0, gap_q});
  assign kg      = k_q + gap_s;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q[AW-1:0];
    wr_data = value_i;
    if (cmd_i.load) begin
      wr_en = !full;
    end else if (cmd_i.wr_shift) begin
      wr_en   = 1'b1;
      wr_addr = kg[AW-1:0];
      wr_data = rd_data_q;
    end else if (cmd_i.wr_held) begin
      wr_en   = 1'b1;
      wr_addr = kg[AW-1:0];
      wr_data = held_q;
    end
  end

  always_comb begin
    rd_en   = cmd_i.rd_i | cmd_i.rd_k | cmd_i.rd_o;
    rd_addr = i_q[AW-1:0];
    if (cmd_i.rd_k) begin
      rd_addr = k_q[AW-1:0];
    end else if (cmd_i.rd_o) begin
      rd_addr = j_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_held) begin
      held_q <= signed'(rd_data_q);
    end
    if (cmd_i.out_ld) begin
      out_value_q <= signed'(rd_data_q);
      final_q     <= stat_o.j_last;
      dropped_q   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      gap_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= cnt_inc;
        if (full) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.init_gap) begin
        gap_q <= cnt_inc >> 1;
      end else if (cmd_i.halve_gap) begin
        gap_q <= gap_q >> 1;
      end
      if (cmd_i.set_i) begin
        i_q <= gap_q;
      end else if (cmd_i.wr_held) begin
        i_q <= i_q + CW'(1);
      end
      if (cmd_i.cap_held) begin
        k_q <= signed'({1'b0, i_q}) - gap_s;
      end else if (cmd_i.wr_shift) begin
        k_q <= k_q - gap_s;
      end
      if (cmd_i.clr_j) begin
        j_q <= '0;
      end else if (cmd_i.out_ld) begin
        j_q <= j_q + CW'(1);
      end
      if (cmd_i.clear_set) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.gap_zero = (gap_q == '0);
  assign stat_o.i_ge_n   = (i_q >= cnt_q);
  assign stat_o.k_neg    = k_q[CW];
  assign stat_o.gt       = signed'(rd_data_q) > held_q;
  assign stat_o.j_last   = (j_q == cnt_q - CW'(1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign final_res_o    = final_q;
  assign dropped_o      = dropped_q;

  `SSE_ASSERT(a_cnt_in_range, cnt_q <= CW'(CAPACITY))
  `SSE_ASSERT(a_shift_k_valid, !(cmd_i.wr_shift || cmd_i.rd_k) || !k_q[CW])
  `SSE_ASSERT_NEXT(a_final_clears, cmd_i.out_ld && cmd_i.clear_set, cnt_q == '0 && !ovf_q)

endmodule

// ===== sv/ssort_ctrl.sv =====
// Controller of the shell sort engine: load, gapped insertion passes
// and output sequencing. Depends on ssort_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ssort_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   last_i,
  output logic                   in_stall_o,
  input  ssort_pkg::ssort_stat_t stat_i,
  output ssort_pkg::ssort_cmd_t  cmd_o
);
  import ssort_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_GAP,
    ST_RD_I,
    ST_HELD,
    ST_RD_K,
    ST_CMP,
    ST_RD_O,
    ST_LD_O
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            cmd_o.init_gap = 1'b1;
            state_d        = ST_GAP;
          end
        end
      end
      ST_GAP: begin
        if (stat_i.gap_zero) begin
          cmd_o.clr_j = 1'b1;
          state_d     = ST_RD_O;
        end else begin
          cmd_o.set_i = 1'b1;
          state_d     = ST_RD_I;
        end
      end
      ST_RD_I: begin
        if (stat_i.i_ge_n) begin
          cmd_o.halve_gap = 1'b1;
          state_d         = ST_GAP;
        end else begin
          cmd_o.rd_i = 1'b1;
          state_d    = ST_HELD;
        end
      end
      ST_HELD: begin
        cmd_o.cap_held = 1'b1;
        state_d        = ST_RD_K;
      end
      ST_RD_K: begin
        if (stat_i.k_neg) begin
          cmd_o.wr_held = 1'b1;
          state_d       = ST_RD_I;
        end else begin
          cmd_o.rd_k = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat_i.gt) begin
          cmd_o.wr_shift = 1'b1;
          state_d        = ST_RD_K;
        end else begin
          cmd_o.wr_held = 1'b1;
          state_d       = ST_RD_I;
        end
      end
      ST_RD_O: begin
        cmd_o.rd_o = 1'b1;
        state_d    = ST_LD_O;
      end
      ST_LD_O: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (stat_i.j_last) begin
            cmd_o.clear_set = 1'b1;
            state_d         = ST_LOAD;
          end else begin
            state_d = ST_RD_O;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_LOAD);

  `SSE_ASSERT_NEXT(a_last_starts_sort, !in_stall_o && in_valid_i && last_i, in_stall_o)
  `SSE_ASSERT_NEXT(a_final_returns, cmd_o.clear_set, !in_stall_o)
  `SSE_ASSERT(a_one_write, !(cmd_o.wr_shift && cmd_o.wr_held) && !(cmd_o.load && cmd_o.out_ld))

endmodule

// ===== sv/shell_sort_engine_core.sv =====
// Shell sort engine, halving gaps, over one single-port element memory.
// Loading takes one cycle per beat and is stalled outside the load phase. On
// the beat marked last the set is sorted: the gap starts at half the set size,
// and each gap pass takes every element from the gap onward as the held one,
// shifts larger elements one gap apart below it up by the gap and writes the
// held element into the hole; the gap is then halved until it reaches zero.
// All of it goes through the one memory port. Results then leave one beat at
// a time, read from the same memory; the next set loads while the final result
// still waits in the output register. Beats that find the memory full are
// dropped and flagged on every result of that set.
// Depends on ssort_pkg, ssort_ctrl and ssort_dp.
module shell_sort_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ssort_pkg::DataW-1:0]  value_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ssort_pkg::DataW-1:0]  sorted_value_o,
  output logic                                final_res_o,
  output logic                                dropped_o
);
  import ssort_pkg::*;

  ssort_cmd_t  cmd;
  ssort_stat_t stat;

  ssort_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ssort_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_i        (value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .sorted_value_o (sorted_value_o),
    .final_res_o    (final_res_o),
    .dropped_o      (dropped_o)
  );

endmodule
